[src/fbfa_pkg.sv]
// ----------------------------------------------------------------------------
// fbfa_pkg
// Shared types and constants of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfa_pkg;

  localparam int DEF_POOL_BLOCKS = 256;

  localparam int CNT_W    = 9;
  localparam int BASE_W   = 32;
  localparam int STRIDE_W = 16;
  localparam int IDX_W    = 8;
  localparam int ADDR_W   = 32;
  localparam int USED_W   = 9;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0]    RST_BLOCK_COUNT = 9'd256;
  localparam logic [BASE_W-1:0]   RST_BASE        = 32'd0;
  localparam logic [STRIDE_W-1:0] RST_STRIDE      = 16'd8;
  localparam logic [STRIDE_W-1:0] MIN_STRIDE      = 16'd8;
  localparam logic [USED_W-1:0]   USED_MAX        = 9'd511;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NULL    = 2'd2,
    STAT_FOREIGN = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT = 2'd0,
    CFG_BASE        = 2'd1,
    CFG_STRIDE      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADDR
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic finish;
  } cmd_t;

endpackage

[src/fbfa_ram.sv]
// ----------------------------------------------------------------------------
// fbfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/fbfa_ctrl.sv]
// ----------------------------------------------------------------------------
// fbfa_ctrl
// Sequencer: capture, execute, address stage, then back to idle.
// ----------------------------------------------------------------------------
module fbfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output fbfa_pkg::cmd_t cmd
);

  import fbfa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_ADDR;
      ST_ADDR: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: cmd.execute = 1'b1;
      ST_ADDR: cmd.finish  = 1'b1;
      default: busy        = 1'b1;
    endcase
  end

endmodule

[src/fbfa_dpath.sv]
// ----------------------------------------------------------------------------
// fbfa_dpath
// Free list state, link store, configuration registers and result registers.
// ----------------------------------------------------------------------------
module fbfa_dpath #(
  parameter int POOL_BLOCKS = fbfa_pkg::DEF_POOL_BLOCKS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fbfa_pkg::cmd_t                       cmd,
  input  logic [fbfa_pkg::MODE_W-1:0]          mode,
  input  logic [fbfa_pkg::IDX_W-1:0]           block_index,
  input  logic                                 is_null,
  input  logic                                 cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 done,
  output logic [fbfa_pkg::STATUS_W-1:0]        status,
  output logic [fbfa_pkg::IDX_W-1:0]           granted_index,
  output logic [fbfa_pkg::ADDR_W-1:0]          granted_address,
  output logic [fbfa_pkg::USED_W-1:0]          blocks_used
);

  import fbfa_pkg::*;

  localparam int PTR_W = $clog2(POOL_BLOCKS + 1);
  localparam int AW    = $clog2(POOL_BLOCKS);
  localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;
  localparam int BW    = (PTR_W > IDX_W) ? PTR_W : IDX_W;
  localparam logic [PTR_W-1:0] END_MARK  = PTR_W'(POOL_BLOCKS);
  localparam logic [CMP_W-1:0] POOL_CMP  = CMP_W'(POOL_BLOCKS);

  logic [CNT_W-1:0]    block_count;
  logic [BASE_W-1:0]   base_address;
  logic [STRIDE_W-1:0] block_stride;

  logic [MODE_W-1:0]   mode_r;
  logic [IDX_W-1:0]    idx_r;
  logic                null_r;

  logic [PTR_W-1:0]    freed_head;
  logic [PTR_W-1:0]    freed_head_next;
  logic [PTR_W-1:0]    watermark;
  logic [PTR_W-1:0]    watermark_next;
  logic [USED_W-1:0]   used;
  logic [USED_W-1:0]   used_next;

  logic [PTR_W-1:0]    link_rdata;
  logic                link_we;

  logic [CMP_W-1:0]    eff_count;
  logic [STRIDE_W-1:0] stride_eff;
  logic [PTR_W-1:0]    blk;
  logic                got;
  status_t             stat;

  status_t             stat_r;
  logic                got_r;
  logic [BW-1:0]       blk_r;
  logic [ADDR_W-1:0]   product_r;

  fbfa_ram #(
    .WIDTH(PTR_W),
    .DEPTH(POOL_BLOCKS)
  ) u_link (
    .clk  (clk),
    .we   (link_we),
    .waddr(AW'(idx_r)),
    .wdata(freed_head),
    .raddr(freed_head[AW-1:0]),
    .rdata(link_rdata)
  );

  assign eff_count  = (CMP_W'(block_count) < POOL_CMP) ? CMP_W'(block_count) : POOL_CMP;
  assign stride_eff = (block_stride < MIN_STRIDE) ? MIN_STRIDE : block_stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count  <= RST_BLOCK_COUNT;
      base_address <= RST_BASE;
      block_stride <= RST_STRIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_COUNT: block_count  <= cfg_data[CNT_W-1:0];
        CFG_BASE:        base_address <= cfg_data[BASE_W-1:0];
        CFG_STRIDE:      block_stride <= cfg_data[STRIDE_W-1:0];
        default:         block_count  <= block_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode;
      idx_r  <= block_index;
      null_r <= is_null;
    end
  end

  always_comb begin
    freed_head_next = freed_head;
    watermark_next  = watermark;
    used_next       = used;
    link_we         = 1'b0;
    blk             = '0;
    got             = 1'b0;
    stat            = STAT_OK;
    case (mode_t'(mode_r))
      MODE_ALLOC: begin
        if (freed_head < END_MARK) begin
          blk             = freed_head;
          freed_head_next = (link_rdata > END_MARK) ? END_MARK : link_rdata;
          got             = 1'b1;
        end else if (CMP_W'(watermark) < eff_count) begin
          blk            = watermark;
          watermark_next = watermark + 1'b1;
          got            = 1'b1;
        end else begin
          stat = STAT_EMPTY;
        end
        if (got && used != USED_MAX) begin
          used_next = used + 1'b1;
        end
      end
      MODE_FREE: begin
        if (null_r) begin
          stat = STAT_NULL;
        end else if (CMP_W'(idx_r) >= eff_count) begin
          stat = STAT_FOREIGN;
        end else begin
          link_we         = cmd.execute;
          freed_head_next = PTR_W'(idx_r);
          if (used != '0) begin
            used_next = used - 1'b1;
          end
        end
      end
      MODE_RESET: begin
        freed_head_next = END_MARK;
        watermark_next  = '0;
        used_next       = '0;
      end
      default: stat = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freed_head <= END_MARK;
      watermark  <= '0;
      used       <= '0;
    end else if (cmd.execute) begin
      freed_head <= freed_head_next;
      watermark  <= watermark_next;
      used       <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      stat_r    <= stat;
      got_r     <= got;
      blk_r     <= BW'(blk);
      product_r <= ADDR_W'(blk) * ADDR_W'(stride_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status          <= stat_r;
      granted_index   <= got_r ? blk_r[IDX_W-1:0] : '0;
      granted_address <= got_r ? base_address + product_r : '0;
      blocks_used     <= used;
    end
  end

endmodule

[src/fixed_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal-size blocks served from a LIFO free list over a fresh-block
// watermark. A command is captured while idle, executed (free list update,
// index times stride), then gets its base added in the address stage, which
// registers done; no new command is taken until idle. The receiver cannot
// stall. Reset empties the freed stack, zeroes watermark and used count and
// restores register defaults; the link store is not cleared.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int POOL_BLOCKS = fbfa_pkg::DEF_POOL_BLOCKS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fbfa_pkg::MODE_W-1:0]      mode,
  input  logic [fbfa_pkg::IDX_W-1:0]       block_index,
  input  logic                             is_null,
  output logic                             done,
  output logic [fbfa_pkg::STATUS_W-1:0]    status,
  output logic [fbfa_pkg::IDX_W-1:0]       granted_index,
  output logic [fbfa_pkg::ADDR_W-1:0]      granted_address,
  output logic [fbfa_pkg::USED_W-1:0]      blocks_used,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import fbfa_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  fbfa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  fbfa_dpath #(
    .POOL_BLOCKS(POOL_BLOCKS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mode           (mode),
    .block_index    (block_index),
    .is_null        (is_null),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .granted_index  (granted_index),
    .granted_address(granted_address),
    .blocks_used    (blocks_used)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed block free list allocator. A scoreboard
// class tracks the free list, the fresh-block watermark, the used count and
// the registers, and predicts one reply per accepted command. Directed
// commands cover the edge cases; random phases over several register settings
// and sender idle rates cover the rest.
// ----------------------------------------------------------------------------
module tb;
  import fbfa_pkg::*;

  localparam int POOL = DEF_POOL_BLOCKS;
  localparam logic [CNT_W-1:0] END_MARK = CNT_W'(POOL);
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   index;
    logic [ADDR_W-1:0]  address;
    logic [USED_W-1:0]  used;
  } reply_t;

  class pool_scoreboard;
    logic [CNT_W-1:0]    link_next [POOL];
    logic [CNT_W-1:0]    stack_top;
    logic [CNT_W-1:0]    fresh_mark;
    logic [USED_W-1:0]   used_count;
    logic [CNT_W-1:0]    count_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [STRIDE_W-1:0] stride_reg;
    reply_t              awaited_replies[$];
    int                  errors;

    function new();
      foreach (link_next[i]) link_next[i] = '0;
      stack_top  = END_MARK;
      fresh_mark = '0;
      used_count = '0;
      count_reg  = RST_BLOCK_COUNT;
      base_reg   = RST_BASE;
      stride_reg = RST_STRIDE;
      errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BLOCK_COUNT: count_reg = data[CNT_W-1:0];
        CFG_BASE:        base_reg = data[BASE_W-1:0];
        CFG_STRIDE:      stride_reg = data[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function reply_t note_request(mode_t m, logic [IDX_W-1:0] idx, logic nul);
      reply_t                r;
      logic [CNT_W-1:0]      limit;
      logic [CNT_W-1:0]      blk;
      logic [ADDR_W-1:0]     step;
      logic                  got;
      r = '0;
      r.status = STAT_OK;
      limit = (count_reg < END_MARK) ? count_reg : END_MARK;
      got = 1'b0;
      blk = '0;
      case (m)
        MODE_ALLOC: begin
          if (stack_top < END_MARK) begin
            blk = stack_top;
            stack_top = link_next[blk[IDX_W-1:0]];
            if (stack_top > END_MARK) stack_top = END_MARK;
            got = 1'b1;
          end else if (fresh_mark < limit) begin
            blk = fresh_mark;
            fresh_mark = fresh_mark + 1'b1;
            got = 1'b1;
          end else begin
            r.status = STAT_EMPTY;
          end
          if (got) begin
            step = (stride_reg < MIN_STRIDE) ? ADDR_W'(MIN_STRIDE) : ADDR_W'(stride_reg);
            r.index = blk[IDX_W-1:0];
            r.address = base_reg + ADDR_W'(blk) * step;
            if (used_count < USED_MAX) used_count = used_count + 1'b1;
          end
        end
        MODE_FREE: begin
          if (nul) begin
            r.status = STAT_NULL;
          end else if (CNT_W'(idx) >= limit) begin
            r.status = STAT_FOREIGN;
          end else begin
            link_next[idx] = stack_top;
            stack_top = CNT_W'(idx);
            if (used_count != 0) used_count = used_count - 1'b1;
          end
        end
        MODE_RESET: begin
          stack_top  = END_MARK;
          fresh_mark = '0;
          used_count = '0;
        end
        default: ;
      endcase
      r.used = used_count;
      awaited_replies.push_back(r);
      return r;
    endfunction

    function void check_reply(logic [STATUS_W-1:0] s, logic [IDX_W-1:0] idx,
                              logic [ADDR_W-1:0] addr, logic [USED_W-1:0] used);
      reply_t e;
      if (awaited_replies.size() == 0) begin
        $error("unexpected reply: status %0d index %0d", s, idx);
        errors++;
        return;
      end
      e = awaited_replies.pop_front();
      if (s !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, s);
        errors++;
      end
      if (idx !== e.index) begin
        $error("granted_index: expected %0d, got %0d", e.index, idx);
        errors++;
      end
      if (addr !== e.address) begin
        $error("granted_address: expected 0x%08h, got 0x%08h", e.address, addr);
        errors++;
      end
      if (used !== e.used) begin
        $error("blocks_used: expected %0d, got %0d", e.used, used);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [MODE_W-1:0]       mode = '0;
  logic [IDX_W-1:0]        block_index = '0;
  logic                    is_null = 1'b0;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [IDX_W-1:0]        granted_index;
  logic [ADDR_W-1:0]       granted_address;
  logic [USED_W-1:0]       blocks_used;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  pool_scoreboard          board;
  logic [IDX_W-1:0]        held_blocks[$];
  int                      idle_pct = 0;
  bit                      start_held = 1'b0;
  int                      quiet_cycles = 0;

  fixed_block_free_list_allocator uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .block_index     (block_index),
    .is_null         (is_null),
    .done            (done),
    .status          (status),
    .granted_index   (granted_index),
    .granted_address (granted_address),
    .blocks_used     (blocks_used),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_reply(status, granted_index, granted_address, blocks_used);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(mode_t m, logic [IDX_W-1:0] idx, logic nul);
    reply_t r;
    start <= 1'b1;
    mode <= m;
    block_index <= idx;
    is_null <= nul;
    do @(posedge clk); while (busy);
    r = board.note_request(m, idx, nul);
    if (m == MODE_ALLOC && r.status == STAT_OK) held_blocks.push_back(r.index);
    if (m == MODE_RESET) held_blocks.delete();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      start_held = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end else begin
      start_held = 1'b1;
    end
  endtask

  // hold off new commands until every reply is in
  task automatic drain();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic load_config(logic [CNT_W-1:0] count, logic [BASE_W-1:0] base,
                             logic [STRIDE_W-1:0] stride);
    cfg_idx_t            idx;
    logic [CFG_DATA_W-1:0] data;
    drain();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin idx = CFG_BLOCK_COUNT; data = CFG_DATA_W'(count); end
        1: begin idx = CFG_BASE; data = CFG_DATA_W'(base); end
        default: begin idx = CFG_STRIDE; data = CFG_DATA_W'(stride); end
      endcase
      cfg_index <= idx;
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_command();
    int               r;
    int               k;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(99);
    if (r < 45) begin
      issue(MODE_ALLOC, IDX_W'($urandom), 1'b0);
    end else if (r < 80 && held_blocks.size() != 0) begin
      k = $urandom_range(held_blocks.size() - 1);
      idx = held_blocks[k];
      held_blocks.delete(k);
      issue(MODE_FREE, idx, 1'b0);
    end else if (r >= 80 && r < 86) begin
      issue(MODE_FREE, IDX_W'($urandom), 1'b0);
    end else if (r >= 86 && r < 91) begin
      issue(MODE_FREE, IDX_W'($urandom), 1'b1);
    end else if (r >= 91 && r < 94) begin
      issue(MODE_RESET, IDX_W'($urandom), 1'($urandom));
    end else if (r >= 94) begin
      issue(MODE_NOP, IDX_W'($urandom), 1'($urandom));
    end else begin
      issue(MODE_ALLOC, IDX_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [CNT_W-1:0]    count;
    logic [BASE_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: register defaults after reset
    issue(MODE_NOP, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_FREE, 8'd255, 1'b0);
    issue(MODE_FREE, 8'd255, 1'b1);
    issue(MODE_FREE, 8'd0, 1'b0);
    issue(MODE_FREE, 8'd1, 1'b0);

    // shrink the pool with blocks still on the freed stack
    load_config(9'd2, 32'hFFFF_FFF0, 16'd3);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_FREE, 8'd2, 1'b0);
    issue(MODE_FREE, 8'd255, 1'b0);
    issue(MODE_FREE, 8'd0, 1'b1);
    issue(MODE_RESET, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_NOP, 8'hFF, 1'b1);

    // double free makes a self-linked block; drive the used count to its clamp
    load_config(9'd1, 32'hFFFF_FFFF, 16'hFFFF);
    issue(MODE_ALLOC, 8'd0, 1'b0);
    issue(MODE_FREE, 8'd0, 1'b0);
    issue(MODE_FREE, 8'd0, 1'b0);
    repeat (515) issue(MODE_ALLOC, 8'd0, 1'b0);
    repeat (3) issue(MODE_FREE, 8'd0, 1'b0);
    issue(MODE_RESET, 8'd0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: count = 9'd1;
        1: count = 9'd256;
        2: count = 9'd511;
        3: count = 9'd0;
        4: count = 9'd3;
        default: count = ($urandom_range(3) == 0) ? 9'd256 : CNT_W'($urandom_range(2, 16));
      endcase
      case (p % 3)
        0: base = 32'd0;
        1: base = 32'hFFFF_FFFF;
        default: base = $urandom;
      endcase
      case (p % 4)
        0: stride = 16'd8;
        1: stride = 16'hFFFF;
        2: stride = STRIDE_W'($urandom_range(0, 7));
        default: stride = STRIDE_W'($urandom);
      endcase
      load_config(count, base, stride);
      issue(MODE_RESET, 8'd0, 1'b0);
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 11;
        default: idle_pct = 56;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 || $urandom_range(199) == 0) drain();
        random_command();
      end
      idle_pct = 0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
